[rtl/core/cab_pkg.sv]
// Shared types and constants for the clipped alpha blit unit.
`default_nettype none

package cab_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);   // row / column counter width
    localparam int DIM_W    = CNT_W + 1;         // clamped source dimension
    localparam int CFG_DW   = 13;                // size register width
    localparam int POS_W    = 14;                // signed position register width
    localparam int CFG_W    = 14;                // config write data width
    localparam int IDX_W    = 3;
    localparam int PIX_W    = 32;
    localparam int OFS_W    = 24;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    typedef enum logic [IDX_W-1:0] {
        REG_DST_WIDTH  = 3'd0,
        REG_DST_HEIGHT = 3'd1,
        REG_DST_STRIDE = 3'd2,
        REG_SRC_WIDTH  = 3'd3,
        REG_SRC_HEIGHT = 3'd4,
        REG_POS_X      = 3'd5,
        REG_POS_Y      = 3'd6,
        REG_BLEND_MODE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DW-1:0]       dst_width;
        logic [CFG_DW-1:0]       dst_height;
        logic [CFG_DW-1:0]       dst_stride;
        logic [CFG_DW-1:0]       src_width;
        logic [CFG_DW-1:0]       src_height;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    blend_mode;
    } t_cfg;

    // One kept pixel on its way from the front to the back.
    typedef struct packed {
        logic [CFG_DW-1:0] dx;
        logic [CFG_DW-1:0] dy;
        logic [PIX_W-1:0]  src;
        logic [PIX_W-1:0]  dst;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

[rtl/core/clipped_alpha_blit_unit.sv]
// Clipped RGBA8888 blit: each kept word passes the queue write, the product stage and
// the output register; one word per cycle sustained while the output is not stalled.
// Throughput is set by the back-end pipeline, which takes one queue word a cycle unless the output stalls.
// The input side stalls only while the 4-word queue is full.
// Synchronous active-low reset clears counters, queue, pipeline valids and
// all configuration registers; no clearing pass.
`default_nettype none

module clipped_alpha_blit_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [13:0] i_cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // src_pixel[31:0], dst_pixel[63:32]
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // dst_offset[23:0], out_pixel[55:24]
);
    import cab_pkg::*;

    t_cfg    r_cfg;
    t_entry  push_entry, head_entry;
    t_q_stat q_stat;
    logic    accept, push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[CFG_DW-1:0];
                REG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[CFG_DW-1:0];
                REG_DST_STRIDE: r_cfg.dst_stride <= i_cfg_data[CFG_DW-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[CFG_DW-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[CFG_DW-1:0];
                REG_POS_X:      r_cfg.pos_x      <= $signed(i_cfg_data[POS_W-1:0]);
                REG_POS_Y:      r_cfg.pos_y      <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BLEND_MODE: r_cfg.blend_mode <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    cab_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_src         (s_tdata[31:0]),
        .i_dst         (s_tdata[63:32]),
        .i_frame_start (s_tuser),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    cab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    cab_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (!q_stat.empty),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_offset  (m_tdata[23:0]),
        .o_pixel   (m_tdata[55:24])
    );

    // only kept words reach the queue
    a_push_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_entry.dx < r_cfg.dst_width) && (push_entry.dy < r_cfg.dst_height))
        else $error("queued pixel outside destination");

    a_no_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_cfg.blend_mode) |-> (push_entry.src[31:24] != 8'd0))
        else $error("transparent pixel queued in blend mode");

    a_empty_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_cfg.src_width == '0 || r_cfg.src_height == '0)) |-> !push)
        else $error("pixel kept with empty source rectangle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[rtl/core/cab_front.sv]
// Front end: raster counters, clipping and the zero-alpha drop.
`default_nettype none

module cab_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cab_pkg::t_cfg       i_cfg,
    input  wire logic           i_accept,
    input  wire logic [31:0]    i_src,
    input  wire logic [31:0]    i_dst,
    input  wire logic           i_frame_start,
    output logic                o_push,
    output cab_pkg::t_entry     o_entry
);
    import cab_pkg::*;

    localparam int XW = (CNT_W + 2 > POS_W + 1) ? CNT_W + 2 : POS_W + 1;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;

    logic [DIM_W-1:0] sw, sh;
    logic [CNT_W-1:0] col0, row0, col1, row1;
    logic [DIM_W-1:0] colp, rowp;
    logic signed [XW-1:0] dx, dy;
    logic             empty_src, in_bounds, alpha_zero;

    always_comb begin
        sw = (int'(i_cfg.src_width)  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_cfg.src_width);
        sh = (int'(i_cfg.src_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_cfg.src_height);
        empty_src = (sw == '0) || (sh == '0);

        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        col1 = ({1'b0, col0} >= sw) ? '0 : col0;
        row1 = ({1'b0, row0} >= sh) ? '0 : row0;

        dx = XW'(i_cfg.pos_x) + XW'({1'b0, col1});
        dy = XW'(i_cfg.pos_y) + XW'({1'b0, row1});
        in_bounds = !dx[XW-1] && !dy[XW-1]
                 && ((XW-1)'(dx) < (XW-1)'(i_cfg.dst_width))
                 && ((XW-1)'(dy) < (XW-1)'(i_cfg.dst_height));
        alpha_zero = i_cfg.blend_mode && (i_src[31:24] == 8'd0);

        colp = {1'b0, col1} + DIM_W'(1);
        rowp = {1'b0, row1} + DIM_W'(1);
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (empty_src) begin
                n_col = '0;
                n_row = '0;
            end else if (colp >= sw) begin
                n_col = '0;
                n_row = (rowp >= sh) ? '0 : CNT_W'(rowp);
            end else begin
                n_col = CNT_W'(colp);
                n_row = row1;
            end
        end

        o_push      = i_accept && !empty_src && in_bounds && !alpha_zero;
        o_entry.dx  = CFG_DW'(dx);
        o_entry.dy  = CFG_DW'(dy);
        o_entry.src = i_src;
        o_entry.dst = i_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cab_queue.sv]
// Short FIFO between the front and back ends.
`default_nettype none

module cab_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cab_pkg::t_entry     i_entry,
    input  wire logic           i_pop,
    output cab_pkg::t_entry     o_entry,
    output cab_pkg::t_q_stat    o_stat
);
    import cab_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr;
    logic [Q_AW-1:0]   r_rd, n_rd;
    logic [Q_AW:0]     r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push)
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
        if (i_pop)
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
        if (i_push && !i_pop)
            n_cnt = r_cnt + (Q_AW+1)'(1);
        else if (!i_push && i_pop)
            n_cnt = r_cnt - (Q_AW+1)'(1);

        o_entry      = r_mem[r_rd];
        o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
        o_stat.empty = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cab_back.sv]
// Back end: offset multiply, per-channel blend and the output register.
`default_nettype none

module cab_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cab_pkg::t_cfg       i_cfg,
    input  wire logic           i_q_valid,
    input  cab_pkg::t_entry     i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [23:0]         o_offset,
    output logic [31:0]         o_pixel
);
    import cab_pkg::*;

    localparam int PW = 2 * CFG_DW;

    // Exact floor(x/255) for x up to 255*255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // stage 1: products
    logic              r_v1;
    logic [PW-1:0]     r_prod;
    logic [CFG_DW-1:0] r_dx;
    logic [15:0]       r_md [3];
    logic [15:0]       r_ms [3];
    logic [PIX_W-1:0]  r_src;
    logic [7:0]        r_dst_a;

    // stage 2: output word
    logic              r_v2;
    logic [OFS_W-1:0]  r_off;
    logic [PIX_W-1:0]  r_pix;

    logic              adv1, adv2;
    logic [7:0]        alpha, inv_alpha;
    logic [7:0]        chan [3];

    always_comb begin
        adv2      = !r_v2 || i_ready;
        adv1      = !r_v1 || adv2;
        o_pop     = adv1 && i_q_valid;
        alpha     = i_entry.src[31:24];
        inv_alpha = 8'hFF - alpha;
        for (int c = 0; c < 3; c++)
            chan[c] = div255(r_md[c]) + div255(r_ms[c]);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod  <= PW'(i_entry.dy) * PW'(i_cfg.dst_stride);
            r_dx    <= i_entry.dx;
            r_src   <= i_entry.src;
            r_dst_a <= i_entry.dst[31:24];
            for (int c = 0; c < 3; c++) begin
                r_md[c] <= 16'(i_entry.dst[8*c +: 8]) * 16'(inv_alpha);
                r_ms[c] <= 16'(i_entry.src[8*c +: 8]) * 16'(alpha);
            end
        end
        if (adv2 && r_v1) begin
            r_off <= OFS_W'(r_prod) + OFS_W'(r_dx);
            r_pix <= i_cfg.blend_mode ? {r_dst_a, chan[2], chan[1], chan[0]} : r_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1)
                r_v1 <= i_q_valid;
            if (adv2)
                r_v2 <= r_v1;
        end
    end

    assign o_valid  = r_v2;
    assign o_offset = r_off;
    assign o_pixel  = r_pix;

endmodule

`default_nettype wire

[tb/tb_clipped_alpha_blit_unit.sv]
// Self-checking testbench for the clipped alpha blit unit: directed table, then random frames.
module tb_clipped_alpha_blit_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cab_pkg::*;

    localparam int SETTLE_CYCLES = 8;     // covers the output pipeline, with margin
    localparam int HOLD_CYCLES   = 80;
    localparam int WORDS_PER_SET = 90;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [PIX_W-1:0] pixel;
    } t_pixel_write;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_WRITE
    } t_row_check;

    typedef struct packed {
        logic [2:0]       setting;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        logic             fs;
        t_row_check       chk;
        logic [OFS_W-1:0] offset;
        logic [PIX_W-1:0] pixel;
    } t_dir_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = 3'd0;
    logic [13:0] i_cfg_data = 14'd0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata    = 64'd0;  // src_pixel[31:0], dst_pixel[63:32]
    logic        s_tuser    = 1'b0;   // frame_start
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [55:0] m_tdata;             // dst_offset[23:0], out_pixel[55:24]

    t_cfg         blit_cfg = '0;
    int           col_pos  = 0;
    int           row_pos  = 0;
    t_pixel_write pending_writes[$];
    int           mismatch_count = 0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_serial = 0;
    int hold_taken  = 0;
    int hold_left   = 0;

    int send_idle_plan [4] = '{0, 65, 0, 11};
    int recv_stall_plan[4] = '{0, 0, 65, 11};

    t_cfg     directed_settings [6];
    t_dir_row directed_rows [22];

    clipped_alpha_blit_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] mix_channel(input logic [7:0] d, input logic [7:0] s,
                                               input logic [7:0] a);
        return 8'((int'(d) * (255 - int'(a))) / 255 + (int'(s) * int'(a)) / 255);
    endfunction

    // Advances the raster position and works out the write, if any, for one source word
    task automatic place_pixel(input logic [31:0] sp, input logic [31:0] dp, input logic fs,
                               output bit kept, output t_pixel_write wr);
        int          sw, sh, dx, dy;
        logic [31:0] pix;
        longint      ofs;
        kept = 1'b0;
        wr   = '0;
        pix  = sp;
        sw = (blit_cfg.src_width > MAX_DIM) ? MAX_DIM : int'(blit_cfg.src_width);
        sh = (blit_cfg.src_height > MAX_DIM) ? MAX_DIM : int'(blit_cfg.src_height);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (sw == 0 || sh == 0) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            if (col_pos >= sw) col_pos = 0;
            if (row_pos >= sh) row_pos = 0;
            dx = $signed(blit_cfg.pos_x) + col_pos;
            dy = $signed(blit_cfg.pos_y) + row_pos;
            kept = dx >= 0 && dy >= 0 && dx < int'(blit_cfg.dst_width)
                   && dy < int'(blit_cfg.dst_height);
            if (kept && blit_cfg.blend_mode) begin
                if (sp[31:24] == 8'h00) begin
                    kept = 1'b0;
                end else begin
                    pix = {dp[31:24],
                           mix_channel(dp[23:16], sp[23:16], sp[31:24]),
                           mix_channel(dp[15:8], sp[15:8], sp[31:24]),
                           mix_channel(dp[7:0], sp[7:0], sp[31:24])};
                end
            end
            if (kept) begin
                ofs = longint'(dy) * longint'(blit_cfg.dst_stride) + longint'(dx);
                wr.offset = ofs[23:0];
                wr.pixel  = pix;
            end
            col_pos++;
            if (col_pos >= sw) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= sh) row_pos = 0;
            end
        end
    endtask

    task automatic send_word(input logic [31:0] sp, input logic [31:0] dp, input logic fs,
                             input t_row_check chk, input t_pixel_write typed);
        bit           kept;
        t_pixel_write wr;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dp, sp};
        s_tuser  <= fs;
        do @(posedge i_clk); while (!s_tready);
        place_pixel(sp, dp, fs, kept, wr);
        case (chk)
            CHK_MODEL: if (kept) pending_writes.push_back(wr);
            CHK_WRITE: pending_writes.push_back(typed);
            default: ;
        endcase
    endtask

    // Lets every expected write out, then waits SETTLE_CYCLES for dropped words in flight
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [13:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input t_cfg c);
        write_register(REG_DST_WIDTH,  {1'b0, c.dst_width});
        write_register(REG_DST_HEIGHT, {1'b0, c.dst_height});
        write_register(REG_DST_STRIDE, {1'b0, c.dst_stride});
        write_register(REG_SRC_WIDTH,  {1'b0, c.src_width});
        write_register(REG_SRC_HEIGHT, {1'b0, c.src_height});
        write_register(REG_POS_X,      c.pos_x);
        write_register(REG_POS_Y,      c.pos_y);
        write_register(REG_BLEND_MODE, {13'd0, c.blend_mode});
        i_cfg_we <= 1'b0;
        blit_cfg = c;
    endtask

    function automatic t_cfg random_setting();
        t_cfg c;
        int   px, py;
        c = '0;
        if ($urandom_range(4) == 0) begin
            // wide buffer, full register range, source kept small
            c.dst_width  = CFG_DW'($urandom_range(8191));
            c.dst_height = CFG_DW'($urandom_range(8191));
            c.dst_stride = CFG_DW'($urandom_range(8191));
            px = $urandom_range(1) ? $urandom_range(16383)
                                   : int'(c.dst_width) - int'($urandom_range(8));
            py = $urandom_range(1) ? $urandom_range(16383)
                                   : int'(c.dst_height) - int'($urandom_range(8));
        end else begin
            c.dst_width  = CFG_DW'($urandom_range(1, 12));
            c.dst_height = CFG_DW'($urandom_range(1, 12));
            c.dst_stride = ($urandom_range(4) == 0)
                         ? CFG_DW'($urandom_range(0, 32'(c.dst_width)))
                         : CFG_DW'(32'(c.dst_width) + $urandom_range(3));
            px = int'($urandom_range(18)) - 6;
            py = int'($urandom_range(18)) - 6;
        end
        c.src_width  = CFG_DW'($urandom_range(1, 10));
        c.src_height = CFG_DW'($urandom_range(1, 10));
        c.pos_x      = POS_W'(px);
        c.pos_y      = POS_W'(py);
        c.blend_mode = 1'($urandom_range(1));
        return c;
    endfunction

    // Mostly whole frames opened by frame_start, some cut short, odd stray restarts
    task automatic stream_frames(input int n_words);
        int          sent, frame_len, k, sw, sh;
        logic [31:0] sp;
        sent = 0;
        sw = (blit_cfg.src_width > MAX_DIM) ? MAX_DIM : int'(blit_cfg.src_width);
        sh = (blit_cfg.src_height > MAX_DIM) ? MAX_DIM : int'(blit_cfg.src_height);
        while (sent < n_words) begin
            frame_len = sw * sh;
            if ($urandom_range(9) == 0) frame_len = $urandom_range(1, frame_len);
            for (k = 0; k < frame_len && sent < n_words; k++) begin
                sp = $urandom;
                case ($urandom_range(3))
                    0: sp[31:24] = 8'h00;
                    1: sp[31:24] = 8'hff;
                    default: ;
                endcase
                send_word(sp, $urandom,
                          (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                          CHK_MODEL, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : sink_ready
        if (hold_serial != hold_taken) begin
            hold_taken = hold_serial;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : write_check
        t_pixel_write want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual offset %h pixel %h",
                         $time, m_tdata[23:0], m_tdata[55:24]);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                if (m_tdata[23:0] !== want.offset) begin
                    $display("%0t: dst_offset expected %h actual %h",
                             $time, want.offset, m_tdata[23:0]);
                    mismatch_count++;
                end
                if (m_tdata[55:24] !== want.pixel) begin
                    $display("%0t: out_pixel expected %h actual %h",
                             $time, want.pixel, m_tdata[55:24]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int   r, p, k, cur;
        t_cfg c;

        // dst_w, dst_h, stride, src_w, src_h, pos_x, pos_y, blend
        directed_settings = '{
            '{13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    14'sd0,     14'sd0,    1'b0},
            '{13'd4,    13'd4,    13'd4,    13'd3,    13'd2,    14'sd0,     14'sd0,    1'b0},
            '{13'd4,    13'd4,    13'd4,    13'd3,    13'd2,    -14'sd1,    14'sd3,    1'b1},
            '{13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191, 14'sd0,     14'sd8190, 1'b0},
            '{13'd8191, 13'd8191, 13'd0,    13'd4096, 13'd1,    -14'sd8192, 14'sd8191, 1'b1},
            '{13'd4,    13'd4,    13'd4,    13'd5,    13'd0,    14'sd0,     14'sd0,    1'b0}
        };
        directed_rows = '{
            // registers still at reset: empty source
            '{3'd0, 32'hffffffff, 32'hffffffff, 1'b1, CHK_NONE,  24'd0,  32'h0},
            '{3'd0, 32'h00000000, 32'h00000000, 1'b0, CHK_NONE,  24'd0,  32'h0},
            // copy, 3x2 source at the origin of a 4x4 buffer
            '{3'd1, 32'h00000000, 32'hffffffff, 1'b1, CHK_WRITE, 24'd0,  32'h00000000},
            '{3'd1, 32'hffffffff, 32'h00000000, 1'b0, CHK_WRITE, 24'd1,  32'hffffffff},
            '{3'd1, 32'h12345678, 32'h00000000, 1'b0, CHK_WRITE, 24'd2,  32'h12345678},
            '{3'd1, 32'ha5a5a5a5, 32'h00000000, 1'b0, CHK_WRITE, 24'd4,  32'ha5a5a5a5},
            '{3'd1, 32'h5a5a5a5a, 32'h00000000, 1'b1, CHK_WRITE, 24'd0,  32'h5a5a5a5a},
            '{3'd1, 32'h0f0f0f0f, 32'h00000000, 1'b0, CHK_WRITE, 24'd1,  32'h0f0f0f0f},
            // blend at (-1,3): left column and second row clipped
            '{3'd2, 32'hff112233, 32'h44556677, 1'b1, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'hff112233, 32'h44556677, 1'b0, CHK_WRITE, 24'd12, 32'h44112233},
            '{3'd2, 32'h00abcdef, 32'h12345678, 1'b0, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'h80ff00ff, 32'h00000000, 1'b0, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'h80ff00ff, 32'h00000000, 1'b0, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'hffffffff, 32'hffffffff, 1'b0, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'h80ff0000, 32'hff0000ff, 1'b0, CHK_NONE,  24'd0,  32'h0},
            '{3'd2, 32'h80ff0000, 32'hff0000ff, 1'b0, CHK_MODEL, 24'd0,  32'h0},
            '{3'd2, 32'h01ffffff, 32'h00000000, 1'b0, CHK_MODEL, 24'd0,  32'h0},
            // largest registers, offset wraps past 24 bits
            '{3'd3, 32'hdeadbeef, 32'h00000000, 1'b1, CHK_MODEL, 24'd0,  32'h0},
            '{3'd3, 32'h00000001, 32'hffffffff, 1'b0, CHK_MODEL, 24'd0,  32'h0},
            // most negative column, all clipped
            '{3'd4, 32'hffffffff, 32'h00000000, 1'b1, CHK_NONE,  24'd0,  32'h0},
            '{3'd4, 32'h80808080, 32'h00000000, 1'b0, CHK_NONE,  24'd0,  32'h0},
            // zero source height only
            '{3'd5, 32'hffffffff, 32'hffffffff, 1'b1, CHK_NONE,  24'd0,  32'h0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur = 0;
        for (r = 0; r < 22; r++) begin
            if (directed_rows[r].setting != cur) begin
                drain_writes();
                cur = directed_rows[r].setting;
                load_setting(directed_settings[cur]);
            end
            send_word(directed_rows[r].src, directed_rows[r].dst, directed_rows[r].fs,
                      directed_rows[r].chk,
                      {directed_rows[r].offset, directed_rows[r].pixel});
        end

        // back-pressure: sink holds off while words keep coming, so the queue fills
        drain_writes();
        c = '0;
        c.dst_width  = 13'd64;
        c.dst_height = 13'd64;
        c.dst_stride = 13'd64;
        c.src_width  = 13'd8;
        c.src_height = 13'd8;
        load_setting(c);
        hold_serial++;
        for (k = 0; k < 40; k++) send_word($urandom, $urandom, k == 0, CHK_MODEL, '0);
        drain_writes();
        for (k = 0; k < 30; k++) send_word($urandom, $urandom, 1'b0, CHK_MODEL, '0);

        for (p = 0; p < 4; p++) begin
            drain_writes();
            idle_pct  = send_idle_plan[p];
            stall_pct = recv_stall_plan[p];
            for (k = 0; k < 3; k++) begin
                drain_writes();
                load_setting(random_setting());
                stream_frames(WORDS_PER_SET);
            end
        end

        // oversized source rectangle, first row clipped on the left
        drain_writes();
        idle_pct  = 0;
        stall_pct = 0;
        c = '0;
        c.dst_width  = 13'd8191;
        c.dst_height = 13'd8191;
        c.dst_stride = 13'd8191;
        c.src_width  = CFG_DW'($urandom_range(4097, 8191));
        c.src_height = 13'd8191;
        c.pos_x      = -14'sd60;
        load_setting(c);
        for (k = 0; k < 160; k++) send_word($urandom, $urandom, k == 0, CHK_MODEL, '0);

        drain_writes();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cab_pkg.sv
rtl/core/cab_front.sv
rtl/core/cab_queue.sv
rtl/core/cab_back.sv
rtl/core/clipped_alpha_blit_unit.sv
tb/tb_clipped_alpha_blit_unit.sv
